// ===== src/gpr_pkg.sv =====
package gpr_pkg;

  // glyph geometry
  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int GLYPH_BITS   = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int NUM_GLYPHS   = 41;
  localparam int COL_W        = $clog2(GLYPH_WIDTH);
  localparam int IDX_W        = $clog2(NUM_GLYPHS);

  // configuration register indexes
  localparam logic CFG_PIXEL_SCALE = 1'b0;
  localparam logic CFG_INK_COLOR   = 1'b1;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;

  // glyph rom slots of the punctuation
  localparam logic [IDX_W-1:0] G_SPACE  = IDX_W'(36);
  localparam logic [IDX_W-1:0] G_COLON  = IDX_W'(37);
  localparam logic [IDX_W-1:0] G_SLASH  = IDX_W'(38);
  localparam logic [IDX_W-1:0] G_DASH   = IDX_W'(39);
  localparam logic [IDX_W-1:0] G_PERIOD = IDX_W'(40);
  localparam logic [IDX_W-1:0] G_ALPHA  = IDX_W'(10);

  // whole glyph, row 0 in the top bits, leftmost column first
  typedef logic [GLYPH_BITS-1:0] glyph_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } gpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bits_empty;
    logic out_free;
  } gpr_status_t;

  localparam glyph_t FONT_ROM [NUM_GLYPHS] = '{
    {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
    {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
    {5'h1F,5'h01,5'h02,5'h06,5'h01,5'h11,5'h0E},
    {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
    {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
    {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E},
    {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
    {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E},
    {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
    {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
    {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
    {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
    {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
    {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E},
    {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
    {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
    {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
    {5'h11,5'h19,5'h15,5'h15,5'h13,5'h11,5'h11},
    {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
    {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
    {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
    {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
    {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
    {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
    {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
    {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
    {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00},
    {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10},
    {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06}
  };

  // bitmap for a character code, all zero when the code has no glyph
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [IDX_W-1:0] idx;
    logic             hit;
    idx = '0;
    hit = 1'b1;
    if (code >= CH_0 && code <= CH_9) begin
      idx = IDX_W'(code - CH_0);
    end else if (code >= CH_UA && code <= CH_UZ) begin
      idx = G_ALPHA + IDX_W'(code - CH_UA);
    end else if (code >= CH_LA && code <= CH_LZ) begin
      idx = G_ALPHA + IDX_W'(code - CH_LA);
    end else begin
      case (code)
        CH_SPACE:  idx = G_SPACE;
        CH_COLON:  idx = G_COLON;
        CH_SLASH:  idx = G_SLASH;
        CH_DASH:   idx = G_DASH;
        CH_PERIOD: idx = G_PERIOD;
        default:   hit = 1'b0;
      endcase
    end
    return hit ? FONT_ROM[idx] : '0;
  endfunction

endpackage

// ===== src/gpr_ctrl.sv =====
module gpr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpr_pkg::gpr_status_t status,
  output gpr_pkg::gpr_cmd_t    cmd
);
  import gpr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r;
  logic state_nxt;

  // take a request only when no glyph is being scanned
  assign in_stall  = (state_r != ST_IDLE);
  assign cmd.load  = (state_r == ST_IDLE) && in_valid;
  assign cmd.step  = (state_r == ST_SCAN) && !status.bits_empty && status.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.bits_empty) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/gpr_datapath.sv =====
module gpr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  gpr_pkg::gpr_cmd_t    cmd,
  output gpr_pkg::gpr_status_t status,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          in_char_code,
  input  logic signed [15:0]  in_origin_x,
  input  logic signed [15:0]  in_origin_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_rect_x,
  output logic signed [15:0]  out_rect_y,
  output logic [7:0]          out_rect_size,
  output logic [15:0]         out_rect_color,
  output logic                out_last_square
);
  import gpr_pkg::*;

  logic [7:0]       scale_r;
  logic [15:0]      color_r;
  glyph_t           bits_r,  bits_nxt;
  logic [COL_W-1:0] col_r,   col_nxt;
  logic [15:0]      ox_r;
  logic [15:0]      x_r,     x_nxt;
  logic [15:0]      y_r,     y_nxt;
  logic             ovld_r,  ovld_nxt;
  logic [15:0]      ox_out_r, oy_out_r;
  logic             olast_r;
  logic [15:0]      scale_ext;
  logic             lit;

  assign scale_ext = {8'd0, scale_r};
  assign lit       = bits_r[GLYPH_BITS-1];

  assign status.bits_empty = (bits_r == '0);
  assign status.out_free   = !ovld_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 8'd1;
      color_r <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PIXEL_SCALE: scale_r <= cfg_data[7:0];
        CFG_INK_COLOR:   color_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // glyph shift register and pixel position walk
  always_comb begin
    bits_nxt = bits_r;
    col_nxt  = col_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (cmd.load) begin
      bits_nxt = (scale_r == 8'd0) ? '0 : glyph_lookup(in_char_code);
      col_nxt  = '0;
      x_nxt    = in_origin_x;
      y_nxt    = in_origin_y;
    end else if (cmd.step) begin
      bits_nxt = {bits_r[GLYPH_BITS-2:0], 1'b0};
      if (col_r == COL_W'(GLYPH_WIDTH - 1)) begin
        col_nxt = '0;
        x_nxt   = ox_r;
        y_nxt   = y_r + scale_ext;
      end else begin
        col_nxt = col_r + COL_W'(1);
        x_nxt   = x_r + scale_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else begin
      bits_r <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    if (cmd.load) ox_r <= in_origin_x;
  end

  // output register
  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.step && lit) begin
      ovld_nxt = 1'b1;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && lit) begin
      ox_out_r <= x_r;
      oy_out_r <= y_r;
      olast_r  <= (bits_r[GLYPH_BITS-2:0] == '0);
    end
  end

  assign out_valid       = ovld_r;
  assign out_rect_x      = ox_out_r;
  assign out_rect_y      = oy_out_r;
  assign out_rect_size   = scale_r;
  assign out_rect_color  = color_r;
  assign out_last_square = olast_r;

endmodule

// ===== src/glyph_pixel_rasterizer_top.sv =====
// channel  | direction | handshake         | payload
// in       | input     | in_valid/in_stall | char_code, origin_x, origin_y
// out      | output    | out_valid/out_stall | rect_x, rect_y, rect_size, rect_color, last_square
// cfg      | input     | cfg_wr_en         | cfg_index, cfg_data
//
// a character walks up to 35 glyph cells, one cell a cycle, and the walk ends
// at the last lit cell; a request is accepted in idle, walked in the scan
// state and followed by a return to idle, also when nothing is drawn
// one square leaves per cycle through a single output register; a square held
// by a stalled output holds the walk
// a new request is taken once the walk of the previous one has finished
// reset (rst_n low, synchronous) sets scale 1 and colour 0xffff
module glyph_pixel_rasterizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_rect_x,
  output logic signed [15:0] out_rect_y,
  output logic [7:0]         out_rect_size,
  output logic [15:0]        out_rect_color,
  output logic               out_last_square,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import gpr_pkg::*;

  gpr_cmd_t    cmd;
  gpr_status_t status;

  // sequencer
  gpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // glyph walk and output stage
  gpr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_char_code    (in_char_code),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_size   (out_rect_size),
    .out_rect_color  (out_rect_color),
    .out_last_square (out_last_square)
  );

endmodule

// ===== src/gpr_checker.sv =====
module gpr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] out_rect_x,
  input logic signed [15:0] out_rect_y,
  input logic [7:0]        out_rect_size,
  input logic              out_last_square
);

  // a stalled square stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("square dropped while stalled");

  // a stalled square keeps its corner
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rect_x) && $stable(out_rect_y))
    else $error("square corner changed while stalled");

  // zero scale never produces a square
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_size != 8'd0)
    else $error("square of size zero");

  // after a square that is not the last, the glyph is still being walked
  a_busy_mid_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_square |=> in_stall)
    else $error("new request taken before the glyph finished");

endmodule

bind glyph_pixel_rasterizer_top gpr_checker u_gpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rect_x      (out_rect_x),
  .out_rect_y      (out_rect_y),
  .out_rect_size   (out_rect_size),
  .out_last_square (out_last_square)
);

// ===== sim/tb_glyph_pixel_rasterizer_top.sv =====
module tb_glyph_pixel_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpr_pkg::*;

  // one filled square as it leaves the block
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         size;
    logic [15:0]        color;
    logic               last;
  } square_t;

  // 5x7 font, row 0 in the top bits, leftmost column first
  localparam bit [34:0] FONT [41] = '{
    {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
    {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
    {5'h1F,5'h01,5'h02,5'h06,5'h01,5'h11,5'h0E},
    {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
    {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
    {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E},
    {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
    {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E},
    {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
    {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
    {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
    {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
    {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
    {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E},
    {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
    {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
    {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
    {5'h11,5'h19,5'h15,5'h15,5'h13,5'h11,5'h11},
    {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
    {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
    {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
    {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
    {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
    {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
    {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
    {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
    {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00},
    {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10},
    {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06}
  };

  // codes with no glyph, around the edges of the glyph ranges
  localparam logic [7:0] NO_GLYPH_CODES [7] = '{
    8'h00, 8'h23, 8'h40, 8'h5B, 8'h7B, 8'h80, 8'hFF
  };
  localparam logic [7:0] PUNCT_CODES [5] = '{
    CH_SPACE, CH_COLON, CH_SLASH, CH_DASH, CH_PERIOD
  };

  // walk of one character plus the return to idle, with margin
  localparam int WALK_CYCLES = 40;

  // predicts the squares of each request and checks them in order
  class square_tracker;
    logic [7:0]  scale;
    logic [15:0] ink;
    square_t     expected_squares[$];
    int          mismatches;

    function new();
      scale      = 8'd1;
      ink        = 16'hFFFF;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] data);
      if (idx == CFG_PIXEL_SCALE) begin
        scale = data[7:0];
      end else begin
        ink = data;
      end
    endfunction

    // font slot of a code, -1 when it has none
    function int slot_of(logic [7:0] code);
      if (code >= CH_0 && code <= CH_9) return int'(code - CH_0);
      if (code >= CH_UA && code <= CH_UZ) return int'(G_ALPHA) + int'(code - CH_UA);
      if (code >= CH_LA && code <= CH_LZ) return int'(G_ALPHA) + int'(code - CH_LA);
      case (code)
        CH_SPACE:  return int'(G_SPACE);
        CH_COLON:  return int'(G_COLON);
        CH_SLASH:  return int'(G_SLASH);
        CH_DASH:   return int'(G_DASH);
        CH_PERIOD: return int'(G_PERIOD);
        default:   return -1;
      endcase
    endfunction

    function void add_char(logic [7:0] code, logic [15:0] ox, logic [15:0] oy);
      int        slot;
      bit [34:0] cells;
      square_t   sq;
      bit        have;
      slot = slot_of(code);
      if (slot < 0 || scale == 8'd0) return;
      cells = FONT[slot];
      have  = 1'b0;
      sq    = '0;
      // row-major scan, each lit cell queued once the next one is known
      for (int r = 0; r < GLYPH_HEIGHT; r++) begin
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
          if (cells[GLYPH_BITS - 1 - (r * GLYPH_WIDTH + c)]) begin
            if (have) expected_squares.push_back(sq);
            sq.x     = ox + 16'(c * scale);
            sq.y     = oy + 16'(r * scale);
            sq.size  = scale;
            sq.color = ink;
            sq.last  = 1'b0;
            have     = 1'b1;
          end
        end
      end
      if (have) begin
        sq.last = 1'b1;
        expected_squares.push_back(sq);
      end
    endfunction

    function void check_square(square_t got);
      square_t want;
      if (expected_squares.size() == 0) begin
        $error("unexpected square at x %0d y %0d", got.x, got.y);
        mismatches++;
        return;
      end
      want = expected_squares.pop_front();
      if (got.x !== want.x) begin
        $error("rect_x: expected %0d, got %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("rect_y: expected %0d, got %0d", want.y, got.y);
        mismatches++;
      end
      if (got.size !== want.size) begin
        $error("rect_size: expected %0d, got %0d", want.size, got.size);
        mismatches++;
      end
      if (got.color !== want.color) begin
        $error("rect_color: expected %h, got %h", want.color, got.color);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_square: expected %b, got %b", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_squares.size();
    endfunction
  endclass

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code    = '0;
  logic signed [15:0] in_origin_x     = '0;
  logic signed [15:0] in_origin_y     = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic signed [15:0] out_rect_x;
  logic signed [15:0] out_rect_y;
  logic [7:0]         out_rect_size;
  logic [15:0]        out_rect_color;
  logic               out_last_square;
  logic               cfg_wr_en       = 1'b0;
  logic               cfg_index       = CFG_PIXEL_SCALE;
  logic [15:0]        cfg_data        = '0;
  logic [7:0]         stall_tick      = '0;

  square_tracker tracker = new();

  glyph_pixel_rasterizer_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_size   (out_rect_size),
    .out_rect_color  (out_rect_color),
    .out_last_square (out_last_square),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, mode taken from the top two bits of a free-running tick counter
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_tick <= '0;
    end else begin
      stall_tick <= stall_tick + 8'd1;
      case (stall_tick[7:6])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
        2'd2:    out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (stall_tick[2:0] < 3'd5);
      endcase
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.add_char(in_char_code, in_origin_x, in_origin_y);
      if (out_valid && !out_stall) begin
        tracker.check_square({out_rect_x, out_rect_y, out_rect_size,
                              out_rect_color, out_last_square});
      end
    end
  end

  // present one request and hold it until taken
  task automatic send_req(logic [7:0] code, logic [15:0] ox, logic [15:0] oy);
    in_valid     <= 1'b1;
    in_char_code <= code;
    in_origin_x  <= ox;
    in_origin_y  <= oy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender pauses until every expected square has come
  // the queue is checked only after the monitor has noted the last accepted request
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // drained and the walk of a request with no squares is over too
  task automatic wait_idle();
    drain();
    repeat (WALK_CYCLES) @(posedge clk);
  endtask

  // write both registers while idle, junk in the unused scale bits
  task automatic configure(logic [7:0] scale, logic [15:0] color);
    logic [15:0] scale_word;
    scale_word = {8'($urandom_range(0, 255)), scale};
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PIXEL_SCALE;
    cfg_data  <= scale_word;
    @(posedge clk);
    tracker.set_register(CFG_PIXEL_SCALE, scale_word);
    cfg_index <= CFG_INK_COLOR;
    cfg_data  <= color;
    @(posedge clk);
    tracker.set_register(CFG_INK_COLOR, color);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly drawable codes, some of anything
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return CH_0 + 8'($urandom_range(0, 9));
      3, 4, 5: return CH_UA + 8'($urandom_range(0, 25));
      6, 7:    return CH_LA + 8'($urandom_range(0, 25));
      default: return PUNCT_CODES[$urandom_range(0, 4)];
    endcase
  endfunction

  // random coordinate, now and then near the wrap point
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF - 16'($urandom_range(0, 40));
      1:       return 16'h8000 + 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // random requests in bursts with gaps between them
  task automatic play_random(int count);
    int left;
    int gap;
    left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      send_req(pick_char(), pick_coord(), pick_coord());
      left--;
      if (left == 0) begin
        left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        gap  = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // stimulus
  initial begin
    logic [7:0]  scale;
    logic [15:0] color;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: every glyph class, field extremes, codes with no glyph
    send_req(CH_0, 16'h0000, 16'h0000);
    send_req(CH_9, 16'h7FFF, 16'h7FFF);
    send_req(CH_UA, 16'h8000, 16'h8000);
    send_req(CH_UZ, 16'hFFFF, 16'h0001);
    send_req(CH_LA, 16'h7FFE, 16'hFFFC);
    send_req(CH_LZ, 16'h1234, 16'h8001);
    send_req(CH_SPACE, 16'h0100, 16'h0100);
    send_req(CH_COLON, 16'hFFFF, 16'hFFFF);
    send_req(CH_SLASH, 16'h5555, 16'hAAAA);
    send_req(CH_DASH, 16'hAAAA, 16'h5555);
    send_req(CH_PERIOD, 16'h7FFC, 16'h7FFB);
    for (int i = 0; i < 7; i++) send_req(NO_GLYPH_CODES[i], 16'h0010, 16'h0020);

    // zero scale draws nothing
    configure(8'd0, 16'h1234);
    send_req(CH_0 + 8'd8, 16'h0000, 16'h0000);
    send_req(CH_UA + 8'd22, 16'h7FFF, 16'h8000);
    send_req(CH_PERIOD, 16'hFFFF, 16'hFFFF);

    // widest squares wrap past the coordinate edges
    configure(8'd255, 16'h0000);
    send_req(CH_0 + 8'd8, 16'h7FFF, 16'h7FFF);
    send_req(CH_UA + 8'd22, 16'h8000, 16'h8000);
    send_req(CH_UA + 8'd12, 16'hFF00, 16'h7F00);
    play_random(30);

    // several settings of random requests, one with a full pause inside
    for (int p = 0; p < 6; p++) begin
      color = 16'($urandom_range(0, 65535));
      case (p)
        0:       scale = 8'd2;
        1:       scale = 8'd1;
        2: begin
          scale = 8'd3;
          color = 16'hFFFF;
        end
        3:       scale = 8'd255;
        4:       scale = 8'($urandom_range(1, 8));
        default: scale = 8'($urandom_range(1, 255));
      endcase
      configure(scale, color);
      if (p == 1) begin
        play_random(18);
        drain();
        play_random(17);
      end else begin
        play_random(35);
      end
    end

    wait_idle();
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== glyph_pixel_rasterizer_top.f =====
src/gpr_pkg.sv
src/gpr_ctrl.sv
src/gpr_datapath.sv
src/glyph_pixel_rasterizer_top.sv
src/gpr_checker.sv
sim/tb_glyph_pixel_rasterizer_top.sv
